### rtl/arxsh_pkg.sv
// ----------------------------------------------------------------------------
// arxsh_pkg: shared types and constants for the ARX stream hash
// Job record between front and back, state word type, mix round function.
// ----------------------------------------------------------------------------
`default_nettype none

package arxsh_pkg;

  localparam int unsigned BlockBytes = 32;
  localparam int unsigned MixRounds  = 7;

  typedef logic [3:0][63:0] words_t;

  localparam words_t InitWords = {
    64'h894e29b9611eb173, 64'hca50864d814cbc2e,
    64'he22d4dea68577f34, 64'h5d6daffc4411a967
  };

  // one unit of work for the mixing engine
  typedef struct packed {
    logic [8*BlockBytes-1:0] block;   // zero padded, byte 0 in the low bits
    logic                    absorb;  // xor block in and run one mix
    logic                    fin;     // close the message after the absorb
    logic [63:0]             bit_len;
  } job_t;

  function automatic logic [5:0] rot_a(input logic [2:0] idx);
    logic [5:0] r;
    case (idx)
      3'd0:    r = 6'd16;
      3'd1:    r = 6'd14;
      3'd2:    r = 6'd11;
      3'd3:    r = 6'd35;
      3'd4:    r = 6'd57;
      3'd5:    r = 6'd59;
      3'd6:    r = 6'd44;
      default: r = 6'd16;
    endcase
    return r;
  endfunction

  function automatic logic [5:0] rot_b(input logic [2:0] idx);
    logic [5:0] r;
    case (idx)
      3'd0:    r = 6'd28;
      3'd1:    r = 6'd57;
      3'd2:    r = 6'd22;
      3'd3:    r = 6'd34;
      3'd4:    r = 6'd16;
      3'd5:    r = 6'd40;
      3'd6:    r = 6'd13;
      default: r = 6'd28;
    endcase
    return r;
  endfunction

  function automatic logic [63:0] rotl64(input logic [63:0] x, input logic [5:0] n);
    logic [127:0] t;
    t = {x, x} << n;
    return t[127:64];
  endfunction

  // one add-rotate-xor round, words 0 and 1 swapped at the end
  function automatic words_t mix_round(input words_t w, input logic [2:0] idx);
    words_t     r;
    logic [63:0] a, b;
    a    = w[0] + w[2];
    b    = w[1] + w[3];
    r[0] = b;
    r[1] = a;
    r[2] = rotl64(w[2], rot_a(idx)) ^ a;
    r[3] = rotl64(w[3], rot_b(idx)) ^ b;
    return r;
  endfunction

endpackage

`default_nettype wire

### rtl/arxsh_front.sv
// ----------------------------------------------------------------------------
// arxsh_front: byte intake
// Packs bytes into the block buffer, counts the message, emits a job on a
// full block or at the end of the message.
// ----------------------------------------------------------------------------
`default_nettype none

module arxsh_front (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output logic                  in_ready_o,
  input  wire logic [7:0]       data_byte_i,
  input  wire logic             has_byte_i,
  input  wire logic             last_i,
  output logic                  job_push_o,
  output arxsh_pkg::job_t       job_o,
  input  wire logic             job_full_i
);

  localparam int unsigned BufBits  = 8 * arxsh_pkg::BlockBytes;
  localparam int unsigned FillBits = $clog2(arxsh_pkg::BlockBytes);

  logic [BufBits-1:0]  buf_q, buf_d, blk;
  logic [FillBits-1:0] fill_q, fill_d;
  logic [63:0]         cnt_q, cnt_d, cnt_inc;
  logic                acc, blk_full;

  assign in_ready_o = !job_full_i;
  assign acc        = in_valid_i && in_ready_o;
  assign blk_full   = has_byte_i && (fill_q == FillBits'(arxsh_pkg::BlockBytes - 1));
  assign cnt_inc    = cnt_q + {63'd0, has_byte_i};

  always_comb begin
    blk = buf_q;
    if (has_byte_i) begin
      blk[{fill_q, 3'b000} +: 8] = data_byte_i;
    end
  end

  assign job_push_o    = acc && (last_i || blk_full);
  assign job_o.block   = blk;
  assign job_o.absorb  = has_byte_i || (fill_q != '0);
  assign job_o.fin     = last_i;
  assign job_o.bit_len = {cnt_inc[60:0], 3'b000};

  always_comb begin
    buf_d  = buf_q;
    fill_d = fill_q;
    cnt_d  = cnt_q;
    if (acc) begin
      if (job_push_o) begin
        buf_d  = '0;
        fill_d = '0;
      end else begin
        buf_d  = blk;
        fill_d = fill_q + FillBits'(has_byte_i);
      end
      cnt_d = last_i ? 64'd0 : cnt_inc;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      buf_q  <= '0;
      fill_q <= '0;
      cnt_q  <= '0;
    end else begin
      buf_q  <= buf_d;
      fill_q <= fill_d;
      cnt_q  <= cnt_d;
    end
  end

endmodule

`default_nettype wire

### rtl/arxsh_fifo.sv
// ----------------------------------------------------------------------------
// arxsh_fifo: job queue
// Small register queue that decouples byte intake from the mixing engine.
// ----------------------------------------------------------------------------
`default_nettype none

module arxsh_fifo #(
  parameter int unsigned DEPTH = 2
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            push_i,
  input  wire arxsh_pkg::job_t push_data_i,
  output logic                 full_o,
  input  wire logic            pop_i,
  output arxsh_pkg::job_t      head_o,
  output logic                 empty_o
);

  localparam int unsigned PtrBits = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntBits = $clog2(DEPTH + 1);

  arxsh_pkg::job_t [DEPTH-1:0] mem_q;
  logic [PtrBits-1:0]          wr_q, rd_q;
  logic [CntBits-1:0]          cnt_q;

  function automatic logic [PtrBits-1:0] next_ptr(input logic [PtrBits-1:0] p);
    return (p == PtrBits'(DEPTH - 1)) ? '0 : p + PtrBits'(1);
  endfunction

  assign full_o  = (cnt_q == CntBits'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign head_o  = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= next_ptr(wr_q);
      end
      if (pop_i) begin
        rd_q <= next_ptr(rd_q);
      end
      case ({push_i, pop_i})
        2'b10:   cnt_q <= cnt_q + CntBits'(1);
        2'b01:   cnt_q <= cnt_q - CntBits'(1);
        default: cnt_q <= cnt_q;
      endcase
    end
  end

endmodule

`default_nettype wire

### rtl/arxsh_back.sv
// ----------------------------------------------------------------------------
// arxsh_back: mixing engine
// Runs one ARX round per cycle on the state, closes messages and holds the
// digest in an output register.
// ----------------------------------------------------------------------------
`default_nettype none

module arxsh_back (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire arxsh_pkg::job_t job_i,
  input  wire logic            job_empty_i,
  output logic                 job_pop_o,
  output logic                 out_valid_o,
  input  wire logic            out_ready_i,
  output logic [63:0]          digest_first_o,
  output logic [63:0]          digest_second_o
);

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_ABS  = 4'b0010,
    ST_FIN  = 4'b0100,
    ST_DONE = 4'b1000
  } state_e;

  localparam logic [2:0] LastRound = 3'(arxsh_pkg::MixRounds - 1);

  state_e              st_q, st_d;
  arxsh_pkg::words_t   w_q, w_d, rnd;
  logic [2:0]          idx_q, idx_d;
  logic                pass_q, pass_d;
  logic                fin_q, fin_d;
  logic [63:0]         len_q, len_d;
  logic                out_valid_q, out_valid_d, out_load;
  logic [63:0]         dig0_q, dig1_q;

  assign rnd = arxsh_pkg::mix_round(w_q, idx_q);

  always_comb begin
    st_d      = st_q;
    w_d       = w_q;
    idx_d     = idx_q;
    pass_d    = pass_q;
    fin_d     = fin_q;
    len_d     = len_q;
    job_pop_o = 1'b0;
    out_load  = 1'b0;
    case (st_q)
      ST_IDLE: begin
        if (!job_empty_i) begin
          job_pop_o = 1'b1;
          fin_d     = job_i.fin;
          len_d     = job_i.bit_len;
          idx_d     = '0;
          pass_d    = 1'b0;
          if (job_i.absorb) begin
            for (int i = 0; i < 4; i++) begin
              w_d[i] = w_q[i] ^ job_i.block[64*i +: 64];
            end
            st_d = ST_ABS;
          end else begin
            // empty tail: only the length goes in
            w_d[0] = w_q[0] ^ job_i.bit_len;
            st_d   = ST_FIN;
          end
        end
      end
      ST_ABS: begin
        w_d = rnd;
        if (idx_q == LastRound) begin
          idx_d = '0;
          if (fin_q) begin
            w_d[0] = rnd[0] ^ len_q;
            pass_d = 1'b0;
            st_d   = ST_FIN;
          end else begin
            st_d = ST_IDLE;
          end
        end else begin
          idx_d = idx_q + 3'd1;
        end
      end
      ST_FIN: begin
        // two full mixes back to back
        w_d = rnd;
        if (idx_q == LastRound) begin
          idx_d  = '0;
          pass_d = 1'b1;
          if (pass_q) begin
            st_d = ST_DONE;
          end
        end else begin
          idx_d = idx_q + 3'd1;
        end
      end
      ST_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          out_load = 1'b1;
          w_d      = arxsh_pkg::InitWords;
          st_d     = ST_IDLE;
        end
      end
      default: begin
        st_d = ST_IDLE;
      end
    endcase
  end

  assign out_valid_d = out_load ? 1'b1 : (out_ready_i ? 1'b0 : out_valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= ST_IDLE;
      w_q         <= arxsh_pkg::InitWords;
      idx_q       <= '0;
      pass_q      <= 1'b0;
      fin_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      st_q        <= st_d;
      w_q         <= w_d;
      idx_q       <= idx_d;
      pass_q      <= pass_d;
      fin_q       <= fin_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    len_q <= len_d;
    if (out_load) begin
      dig0_q <= w_q[0];
      dig1_q <= w_q[1];
    end
  end

  assign out_valid_o     = out_valid_q;
  assign digest_first_o  = dig0_q;
  assign digest_second_o = dig1_q;

endmodule

`default_nettype wire

### rtl/arx_stream_hash_256_core.sv
// Message close: once the tlast request reaches the engine, tvalid rises after
// the mix of the block it closes (partial or full, if any) and two closing mixes.
// Throughput: one byte per cycle while blocks stream in and the job queue has
// room; the mixing engine runs one round per cycle for each block and for each
// message close. Short messages are bounded by the engine and the job queue depth.
// Reset: asynchronous, active low; state returns to the initial words at once.
// ----------------------------------------------------------------------------
// arx_stream_hash_256_core: streaming 256-bit add-rotate-xor hash
// Byte stream in, 128-bit digest out; intake and mixing run decoupled.
// ----------------------------------------------------------------------------
`default_nettype none

module arx_stream_hash_256_core #(
  parameter int unsigned QUEUE_DEPTH = 2
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          s_axis_tvalid_i,
  output logic               s_axis_tready_o,
  input  wire logic [7:0]    s_axis_tdata_i,   // [7:0] data_byte
  input  wire logic          s_axis_tuser_i,   // [0] has_byte
  input  wire logic          s_axis_tlast_i,
  output logic               m_axis_tvalid_o,
  input  wire logic          m_axis_tready_i,
  output logic [127:0]       m_axis_tdata_o    // [63:0] digest_first, [127:64] digest_second
);

  arxsh_pkg::job_t push_job, head_job;
  logic            push, full, pop, empty;
  logic [63:0]     dig0, dig1;

  arxsh_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid_i),
    .in_ready_o  (s_axis_tready_o),
    .data_byte_i (s_axis_tdata_i),
    .has_byte_i  (s_axis_tuser_i),
    .last_i      (s_axis_tlast_i),
    .job_push_o  (push),
    .job_o       (push_job),
    .job_full_i  (full)
  );

  arxsh_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_job),
    .full_o      (full),
    .pop_i       (pop),
    .head_o      (head_job),
    .empty_o     (empty)
  );

  arxsh_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .job_i           (head_job),
    .job_empty_i     (empty),
    .job_pop_o       (pop),
    .out_valid_o     (m_axis_tvalid_o),
    .out_ready_i     (m_axis_tready_i),
    .digest_first_o  (dig0),
    .digest_second_o (dig1)
  );

  assign m_axis_tdata_o = {dig1, dig0};

endmodule

`default_nettype wire

### sim/tb_arx_stream_hash_256_core.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_arx_stream_hash_256_core: self-checking bench for the ARX stream hash
// Byte messages go in as stream requests and every digest is checked against
// a behavioral hash kept in the bench. Load mixes range from a free-running
// stream to heavy sender gaps and receiver stalls, plus one long output
// hold-off.
// ----------------------------------------------------------------------------

module tb_arx_stream_hash_256_core;

  localparam bit [3:0][63:0] HashSeed = {
    64'h894e29b9611eb173, 64'hca50864d814cbc2e,
    64'he22d4dea68577f34, 64'h5d6daffc4411a967
  };
  localparam bit [6:0][5:0] RotLeftA = {6'd44, 6'd59, 6'd57, 6'd35, 6'd11, 6'd14, 6'd16};
  localparam bit [6:0][5:0] RotLeftB = {6'd13, 6'd40, 6'd16, 6'd34, 6'd22, 6'd57, 6'd28};
  localparam int unsigned BlockLen = 32;

  // content pattern of a message
  typedef enum int {FillRandom, FillZero, FillOnes} fill_kind_e;

  typedef struct packed {
    bit [63:0] digest_second;
    bit [63:0] digest_first;
  } digest_t;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         s_axis_tvalid_i = 1'b0;
  logic         s_axis_tready_o;
  logic [7:0]   s_axis_tdata_i = '0;
  logic         s_axis_tuser_i = 1'b0;
  logic         s_axis_tlast_i = 1'b0;
  logic         m_axis_tvalid_o;
  logic         m_axis_tready_i = 1'b0;
  logic [127:0] m_axis_tdata_o;

  arx_stream_hash_256_core uut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .s_axis_tlast_i  (s_axis_tlast_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // bench copy of the hash state
  bit [3:0][63:0]  hash_w;
  bit [31:0][7:0]  blk_buf;
  int unsigned     blk_fill;
  bit [63:0]       msg_len_bytes;

  digest_t     expected_digests[$];
  int unsigned err_count;
  int unsigned items_sent;
  int unsigned msgs_sent;
  int unsigned bytes_sent;
  int unsigned digests_checked;
  int unsigned idle_pct;
  int unsigned stall_pct;
  int unsigned hold_req;
  int unsigned hold_left;

  function automatic bit [63:0] rol64(bit [63:0] x, bit [5:0] n);
    return (x << n) | (x >> (64 - n));
  endfunction

  function automatic void hash_mix();
    bit [63:0] t;
    for (int r = 0; r < 7; r++) begin
      hash_w[0] += hash_w[2];
      hash_w[1] += hash_w[3];
      hash_w[2] = rol64(hash_w[2], RotLeftA[r]) ^ hash_w[0];
      hash_w[3] = rol64(hash_w[3], RotLeftB[r]) ^ hash_w[1];
      t = hash_w[0];
      hash_w[0] = hash_w[1];
      hash_w[1] = t;
    end
  endfunction

  function automatic void hash_clear();
    hash_w = HashSeed;
    blk_buf = '0;
    blk_fill = 0;
    msg_len_bytes = '0;
  endfunction

  // byte i of the block lands at bits 8i of the flat vector
  function automatic void hash_absorb();
    bit [255:0] flat;
    flat = blk_buf;
    for (int w = 0; w < 4; w++) hash_w[w] ^= flat[w*64 +: 64];
    hash_mix();
    blk_buf = '0;
    blk_fill = 0;
  endfunction

  function automatic void hash_take_item(bit [7:0] b, bit has, bit lst);
    if (has) begin
      blk_buf[blk_fill[4:0]] = b;
      blk_fill++;
      msg_len_bytes++;
      if (blk_fill == BlockLen) hash_absorb();
    end
    if (lst) begin
      if (blk_fill > 0) hash_absorb();
      hash_w[0] ^= msg_len_bytes << 3;
      hash_mix();
      hash_mix();
      expected_digests.push_back('{digest_second: hash_w[1], digest_first: hash_w[0]});
      hash_clear();
    end
  endfunction

  // one request on the input stream; tvalid is only lowered when a gap is taken
  task automatic send_item(bit [7:0] b, bit has, bit lst);
    if ($urandom_range(99) < idle_pct) begin
      s_axis_tvalid_i <= 1'b0;
      s_axis_tdata_i  <= 8'($urandom);
      s_axis_tuser_i  <= 1'($urandom);
      s_axis_tlast_i  <= 1'($urandom);
      @(posedge clk_i);
      while ($urandom_range(99) < idle_pct) @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= b;
    s_axis_tuser_i  <= has;
    s_axis_tlast_i  <= lst;
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
    hash_take_item(b, has, lst);
    if (has || lst) items_sent++;
    if (has) bytes_sent++;
    if (lst) msgs_sent++;
  endtask

  task automatic send_message(int unsigned len, bit end_on_byte, fill_kind_e kind,
                              int unsigned noise_pct);
    bit [7:0] b;
    for (int unsigned i = 0; i < len; i++) begin
      while ($urandom_range(99) < noise_pct) send_item(8'($urandom), 1'b0, 1'b0);
      case (kind)
        FillZero: b = 8'h00;
        FillOnes: b = 8'hff;
        default:  b = 8'($urandom);
      endcase
      send_item(b, 1'b1, end_on_byte && (i == len - 1));
    end
    if (!end_on_byte || len == 0) send_item(8'($urandom), 1'b0, 1'b1);
  endtask

  task automatic wait_digests_drained();
    s_axis_tvalid_i <= 1'b0;
    while (expected_digests.size() != 0) @(posedge clk_i);
  endtask

  task automatic test_directed();
    idle_pct  = 0;
    stall_pct = 0;
    send_item(8'h00, 1'b0, 1'b1);   // empty message
    send_item(8'h5a, 1'b0, 1'b1);   // empty, ignored byte value
    send_item(8'ha5, 1'b0, 1'b0);   // no byte, no end: nothing happens
    send_item(8'hff, 1'b1, 1'b1);
    send_item(8'h00, 1'b1, 1'b1);
    send_item(8'h80, 1'b1, 1'b0);
    send_item(8'h01, 1'b1, 1'b0);
    send_item(8'h7f, 1'b0, 1'b1);
    send_item(8'hff, 1'b0, 1'b1);
    wait_digests_drained();
  endtask

  // partial, exact and overfull blocks with both kinds of message end
  task automatic test_block_boundaries();
    send_message(32, 1'b1, FillOnes, 0);
    send_message(32, 1'b0, FillZero, 0);
    send_message(31, 1'b0, FillRandom, 0);
    send_message(31, 1'b1, FillOnes, 0);
    send_message(33, 1'b1, FillRandom, 5);
    send_message(64, 1'b0, FillRandom, 0);
    send_message(64, 1'b1, FillZero, 0);
    send_message(65, 1'b0, FillOnes, 0);
    wait_digests_drained();
  endtask

  task automatic test_random_traffic(int unsigned idle, int unsigned stall,
                                     int unsigned n_items);
    int unsigned target;
    int unsigned sel;
    int unsigned len;
    target    = items_sent + n_items;
    idle_pct  = idle;
    stall_pct = stall;
    while (items_sent < target) begin
      sel = $urandom_range(99);
      if (sel < 60)      len = $urandom_range(40);
      else if (sel < 85) len = 32 * $urandom_range(1, 3) + $urandom_range(2) - 1;
      else if (sel < 97) len = $urandom_range(100, 41);
      else               len = $urandom_range(300, 200);
      send_message(len, 1'($urandom_range(1)), FillRandom,
                   ($urandom_range(3) == 0) ? 10 : 0);
    end
    wait_digests_drained();
  endtask

  // receiver holds off while short messages pile up behind it
  task automatic test_output_holdoff();
    idle_pct  = 0;
    stall_pct = 0;
    hold_req  = 400;
    repeat (40) send_message($urandom_range(2), 1'($urandom_range(1)), FillRandom, 0);
    wait_digests_drained();
  endtask

  always @(posedge clk_i) begin
    digest_t exp_d;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      if (expected_digests.size() == 0) begin
        $error("digest with no request pending: %h", m_axis_tdata_o);
        err_count++;
      end else begin
        exp_d = expected_digests.pop_front();
        digests_checked++;
        if (m_axis_tdata_o[63:0] !== exp_d.digest_first) begin
          $error("digest_first: expected %h, actual %h", exp_d.digest_first,
                 m_axis_tdata_o[63:0]);
          err_count++;
        end
        if (m_axis_tdata_o[127:64] !== exp_d.digest_second) begin
          $error("digest_second: expected %h, actual %h", exp_d.digest_second,
                 m_axis_tdata_o[127:64]);
          err_count++;
        end
      end
    end
    if (hold_req != 0) begin
      hold_left = hold_req;
      hold_req  = 0;
    end
    if (hold_left != 0) begin
      hold_left--;
      m_axis_tready_i <= 1'b0;
    end else begin
      m_axis_tready_i <= ($urandom_range(99) >= stall_pct);
    end
  end

  initial begin
    err_count       = 0;
    items_sent      = 0;
    msgs_sent       = 0;
    bytes_sent      = 0;
    digests_checked = 0;
    idle_pct        = 0;
    stall_pct       = 0;
    hold_req        = 0;
    hold_left       = 0;
    hash_clear();
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    test_block_boundaries();
    test_random_traffic(0, 0, 200);
    test_output_holdoff();
    test_random_traffic(68, 0, 200);
    test_random_traffic(0, 68, 200);
    test_random_traffic(37, 37, 200);

    s_axis_tvalid_i <= 1'b0;
    wait_digests_drained();
    repeat (40) @(posedge clk_i);

    $display("Covered %0d messages (%0d bytes, %0d input requests), %0d digests checked,",
             msgs_sent, bytes_sent, items_sent, digests_checked);
    $display("under free-running, sender-idle, receiver-stall, mixed and hold-off loads.");
    if (err_count == 0 && expected_digests.size() == 0) begin
      $display("arx_stream_hash_256_core verification clean");
    end else begin
      $display("arx_stream_hash_256_core verification failed");
    end
    $finish;
  end

  initial begin
    #1000000;
    $display("arx_stream_hash_256_core verification failed");
    $finish;
  end

endmodule

### arx_stream_hash_256_core.f
rtl/arxsh_pkg.sv
rtl/arxsh_front.sv
rtl/arxsh_fifo.sv
rtl/arxsh_back.sv
rtl/arx_stream_hash_256_core.sv
sim/tb_arx_stream_hash_256_core.sv
